FILE: hdl/c2c_pkg.sv
// ----------------------------------------------------------------------------
// c2c_pkg
// shared constants for the triplet to compressed column converter
// ----------------------------------------------------------------------------
package c2c_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int INDEX_BITS_DEF  = 16;
  localparam int DIM_W           = 17;
  localparam int VAL_W           = 64;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_CPTR  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

endpackage

FILE: hdl/c2c_store.sv
// ----------------------------------------------------------------------------
// c2c_store
// triplet store: one write port, one registered read port
// ----------------------------------------------------------------------------
module c2c_store #(
  parameter int DEPTH = c2c_pkg::MAX_ENTRIES_DEF,
  parameter int IW    = c2c_pkg::INDEX_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [IW-1:0]           wrow,
  input  logic [IW-1:0]           wcol,
  input  logic [c2c_pkg::VAL_W-1:0] wval,
  input  logic [AW-1:0]           raddr,
  output logic [IW-1:0]           rrow,
  output logic [IW-1:0]           rcol,
  output logic [c2c_pkg::VAL_W-1:0] rval
);

  logic [IW-1:0]             row_mem [DEPTH];
  logic [IW-1:0]             col_mem [DEPTH];
  logic [c2c_pkg::VAL_W-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      row_mem[waddr] <= wrow;
      col_mem[waddr] <= wcol;
      val_mem[waddr] <= wval;
    end
    rrow <= row_mem[raddr];
    rcol <= col_mem[raddr];
    rval <= val_mem[raddr];
  end

endmodule

FILE: hdl/c2c_order.sv
// ----------------------------------------------------------------------------
// c2c_order
// sorted slot list memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module c2c_order #(
  parameter int DEPTH = c2c_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [AW-1:0] rdata
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/coo_to_csc_converter.sv
// ----------------------------------------------------------------------------
// coo_to_csc_converter
// loads (row, column, value) triplets and returns them in column-major
// sorted order, plus column pointers
// ----------------------------------------------------------------------------
// channel  dir  ports
// in       in   in_valid in_ready in_kind in_row_index in_col_index
//               in_value_bits in_position
// out      out  out_valid out_ready out_status out_row out_col out_value
//               out_col_pointer out_entry_count
// cfg      in   cfg_we cfg_index cfg_data
//
// the first entry read after a stored add or a clear first runs an insertion
// sort over the store, through the single read port of each memory.
// reset is synchronous; the memories need no clearing pass.
// a result waits in the output register until taken; the next transfer is
// accepted in the same cycle the result leaves.
// ----------------------------------------------------------------------------
module coo_to_csc_converter #(
  parameter int MAX_ENTRIES = c2c_pkg::MAX_ENTRIES_DEF,
  parameter int INDEX_BITS  = c2c_pkg::INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_kind,
  input  logic [15:0]               in_row_index,
  input  logic [15:0]               in_col_index,
  input  logic [c2c_pkg::VAL_W-1:0] in_value_bits,
  input  logic [c2c_pkg::DIM_W-1:0] in_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [15:0]               out_row,
  output logic [15:0]               out_col,
  output logic [c2c_pkg::VAL_W-1:0] out_value,
  output logic [10:0]               out_col_pointer,
  output logic [10:0]               out_entry_count,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [c2c_pkg::DIM_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = INDEX_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CP    = 4'd1;  // column pointer scan
  localparam logic [3:0] S_SI    = 4'd2;  // sort: fetch key of slot i
  localparam logic [3:0] S_SIW   = 4'd3;
  localparam logic [3:0] S_SJ    = 4'd4;  // sort: read order[j-1]
  localparam logic [3:0] S_SJW   = 4'd5;
  localparam logic [3:0] S_SK    = 4'd6;  // sort: key of that slot ready
  localparam logic [3:0] S_SKW   = 4'd7;
  localparam logic [3:0] S_SCMP  = 4'd8;
  localparam logic [3:0] S_RD    = 4'd9;  // entry: order read
  localparam logic [3:0] S_RDW   = 4'd10;
  localparam logic [3:0] S_RDS   = 4'd11; // entry: store read
  localparam logic [3:0] S_RDD   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_CPW   = 4'd14;

  logic [3:0]                state_r, state_nxt;
  logic [c2c_pkg::DIM_W-1:0] rows_r, cols_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic [c2c_pkg::DIM_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]             i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IW-1:0]             krow_r, krow_nxt, kcol_r, kcol_nxt;
  logic [10:0]               acc_r, acc_nxt;
  logic [AW-1:0]             slot_r, slot_nxt;
  logic                      ovld_r, ovld_nxt;
  logic [1:0]                ost_r, ost_nxt;
  logic [15:0]               orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [c2c_pkg::VAL_W-1:0] oval_r, oval_nxt;
  logic [10:0]               optr_r, optr_nxt;

  logic                      st_we;
  logic [AW-1:0]             st_raddr;
  logic [IW-1:0]             st_rrow, st_rcol;
  logic [c2c_pkg::VAL_W-1:0] st_rval;
  logic                      od_we;
  logic [AW-1:0]             od_waddr, od_wdata, od_raddr, od_rdata;
  logic                      acc_in, acc_out, range_bad;

  assign in_ready  = (state_r == S_IDLE) && (!ovld_r || out_ready);
  assign acc_in    = in_valid && in_ready;
  assign acc_out   = ovld_r && out_ready;
  assign range_bad = ({1'b0, in_row_index} >= rows_r) || ({1'b0, in_col_index} >= cols_r);

  c2c_store #(.DEPTH(MAX_ENTRIES), .IW(IW), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[AW-1:0]),
    .wrow  (IW'(in_row_index)),
    .wcol  (IW'(in_col_index)),
    .wval  (in_value_bits),
    .raddr (st_raddr),
    .rrow  (st_rrow),
    .rcol  (st_rcol),
    .rval  (st_rval)
  );

  c2c_order #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_order (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (od_wdata),
    .raddr (od_raddr),
    .rdata (od_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r;
    pos_nxt    = pos_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    krow_nxt   = krow_r;
    kcol_nxt   = kcol_r;
    acc_nxt    = acc_r;
    slot_nxt   = slot_r;
    ovld_nxt   = ovld_r && !out_ready;
    ost_nxt    = ost_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    oval_nxt   = oval_r;
    optr_nxt   = optr_r;
    st_we      = 1'b0;
    st_raddr   = k_r[AW-1:0];
    od_we      = 1'b0;
    od_waddr   = j_r[AW-1:0];
    od_wdata   = i_r[AW-1:0];
    od_raddr   = k_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          pos_nxt  = in_position;
          orow_nxt = '0;
          ocol_nxt = '0;
          oval_nxt = '0;
          optr_nxt = '0;
          ost_nxt  = c2c_pkg::ST_OK;
          case (in_kind)
            c2c_pkg::KIND_ADD: begin
              if (range_bad) begin
                ost_nxt = c2c_pkg::ST_RANGE;
              end else if (count_r >= CW'(MAX_ENTRIES)) begin
                ost_nxt = c2c_pkg::ST_FULL;
              end else begin
                st_we      = 1'b1;
                count_nxt  = count_r + 1'b1;
                ovalid_nxt = 1'b0;
              end
              state_nxt = S_OUT;
            end
            c2c_pkg::KIND_ENTRY: begin
              if (in_position >= c2c_pkg::DIM_W'(count_r)) begin
                ost_nxt   = c2c_pkg::ST_BADPOS;
                state_nxt = S_OUT;
              end else if (ovalid_r) begin
                state_nxt = S_RD;
              end else begin
                i_nxt     = '0;
                state_nxt = S_SI;
              end
            end
            c2c_pkg::KIND_CPTR: begin
              if (in_position > cols_r) begin
                ost_nxt   = c2c_pkg::ST_BADPOS;
                state_nxt = S_OUT;
              end else begin
                k_nxt     = '0;
                acc_nxt   = '0;
                state_nxt = S_CP;
              end
            end
            default: begin
              count_nxt  = '0;
              ovalid_nxt = 1'b0;
              state_nxt  = S_OUT;
            end
          endcase
        end
      end
      S_CP: begin
        if (k_r >= count_r) begin
          optr_nxt  = acc_r;
          state_nxt = S_OUT;
        end else begin
          st_raddr  = k_r[AW-1:0];
          state_nxt = S_CPW;
        end
      end
      S_CPW: begin
        if (c2c_pkg::DIM_W'(st_rcol) < pos_r) begin
          acc_nxt = acc_r + 1'b1;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_CP;
      end
      S_SI: begin
        if (i_r >= count_r) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_RD;
        end else begin
          st_raddr  = i_r[AW-1:0];
          state_nxt = S_SIW;
        end
      end
      S_SIW: begin
        krow_nxt  = st_rrow;
        kcol_nxt  = st_rcol;
        j_nxt     = i_r;
        state_nxt = S_SJ;
      end
      S_SJ: begin
        if (j_r == '0) begin
          od_we     = 1'b1;
          od_waddr  = j_r[AW-1:0];
          od_wdata  = i_r[AW-1:0];
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SI;
        end else begin
          od_raddr  = AW'(j_r - 1'b1);
          state_nxt = S_SJW;
        end
      end
      S_SJW: begin
        slot_nxt  = od_rdata;
        st_raddr  = od_rdata;
        state_nxt = S_SK;
      end
      S_SK: begin
        st_raddr  = slot_r;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if ((st_rcol > kcol_r) || ((st_rcol == kcol_r) && (st_rrow > krow_r))) begin
          od_we     = 1'b1;
          od_waddr  = j_r[AW-1:0];
          od_wdata  = slot_r;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_SJ;
        end else begin
          od_we     = 1'b1;
          od_waddr  = j_r[AW-1:0];
          od_wdata  = i_r[AW-1:0];
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SI;
        end
      end
      S_RD: begin
        od_raddr  = pos_r[AW-1:0];
        state_nxt = S_RDW;
      end
      S_RDW: begin
        slot_nxt  = od_rdata;
        st_raddr  = od_rdata;
        state_nxt = S_RDS;
      end
      S_RDS: begin
        st_raddr  = slot_r;
        state_nxt = S_RDD;
      end
      S_RDD: begin
        orow_nxt  = 16'(st_rrow);
        ocol_nxt  = 16'(st_rcol);
        oval_nxt  = st_rval;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ovld_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (acc_out && state_r == S_OUT) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      ovld_r   <= 1'b0;
      rows_r   <= c2c_pkg::DIM_W'(65536);
      cols_r   <= c2c_pkg::DIM_W'(65536);
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      ovld_r   <= ovld_nxt;
      if (cfg_we && cfg_index == c2c_pkg::CFG_NUM_ROWS) begin
        rows_r <= cfg_data;
      end
      if (cfg_we && cfg_index == c2c_pkg::CFG_NUM_COLS) begin
        cols_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    krow_r <= krow_nxt;
    kcol_r <= kcol_nxt;
    acc_r  <= acc_nxt;
    slot_r <= slot_nxt;
    ost_r  <= ost_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    oval_r <= oval_nxt;
    optr_r <= optr_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_status      = ost_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_value       = oval_r;
  assign out_col_pointer = optr_r;
  assign out_entry_count = 11'(count_r);

endmodule
